[rtl/report_block_scheduler_assert.svh]
// Assertion macros for the report block scheduler.
// Used by the modules that check their own control logic.
`ifndef REPORT_BLOCK_SCHEDULER_ASSERT_SVH
`define REPORT_BLOCK_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RBS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define RBS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define RBS_ASSERT_IMP(label, clk, rst, a, b)
`define RBS_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[rtl/rbs_pkg.sv]
// Shared types and codes for the report block scheduler.
// No dependencies.
package rbs_pkg;

  localparam int unsigned ADDRESSABLE = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PERIOD  = 2'd1;

  localparam logic [2:0] F_SET_ENABLE  = 3'd0;
  localparam logic [2:0] F_SET_TRIGGER = 3'd1;
  localparam logic [2:0] F_SET_PERIOD  = 3'd2;
  localparam logic [2:0] F_REQUEST_GI  = 3'd3;
  localparam logic [2:0] F_POLL_DUE    = 3'd4;
  localparam logic [2:0] F_COMMIT      = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_RANGE       = 3'd1;
  localparam logic [2:0] ST_DENIED      = 3'd2;
  localparam logic [2:0] ST_INVALID     = 3'd3;
  localparam logic [2:0] ST_UNAVAILABLE = 3'd4;
  localparam logic [2:0] ST_STALE       = 3'd5;

  localparam logic [1:0] R_NONE      = 2'd0;
  localparam logic [1:0] R_GI        = 2'd1;
  localparam logic [1:0] R_INTEGRITY = 2'd2;

  localparam logic [31:0] TRIG_ALLOWED   = 32'h0000_007C;
  localparam logic [7:0]  TRIG_INTEGRITY = 8'h08;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  entry_index;
    logic        enable_flag;
    logic [31:0] setting_value;
    logic [63:0] now_ms;
    logic [31:0] plan_revision;
    logic [7:0]  plan_sequence;
    logic [1:0]  plan_reason;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        due_found;
    logic [3:0]  due_index;
    logic [31:0] due_revision;
    logic [7:0]  due_sequence;
    logic [1:0]  due_reason;
  } rsp_t;

  // request with its classification, as queued between front and back
  typedef struct packed {
    req_t req;
    logic bad_func;
    logic bad_index;
  } qent_t;

endpackage

[rtl/rbs_front.sv]
// Front end: takes requests, classifies them, queues two deep.
// Depends on rbs_pkg.
module rbs_front import rbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] live_count,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       q_valid,
  output qent_t      q_data,
  input  logic       q_pop
);

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  qent_t      cls;

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = slots[rd_ptr];

  always_comb begin
    cls.req       = req;
    cls.bad_func  = (req.func > F_COMMIT);
    cls.bad_index = (req.func != F_POLL_DUE) && ({1'b0, req.entry_index} >= live_count);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

[rtl/rbs_back.sv]
// Back end: entry table, operation sequencer, poll scan and result register.
// Depends on rbs_pkg and report_block_scheduler_assert.svh.
`include "report_block_scheduler_assert.svh"
module rbs_back import rbs_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  live_count,
  input  logic [31:0] min_period,
  input  logic        q_valid,
  input  qent_t       q_data,
  output logic        q_pop,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  localparam int unsigned DEPTH = (MAX_ENTRIES < ADDRESSABLE) ? MAX_ENTRIES : ADDRESSABLE;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_EXEC = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t      state;
  qent_t       cur;
  logic [4:0]  scan_idx;
  logic        scan_pass;
  logic [31:0] effp;

  logic        en_r    [DEPTH];
  logic        pend_r  [DEPTH];
  logic        armed_r [DEPTH];
  logic [63:0] due_r   [DEPTH];
  logic [7:0]  seq_r   [DEPTH];
  logic [31:0] rev_r   [DEPTH];
  logic [7:0]  trig_r  [DEPTH];
  logic [31:0] per_r   [DEPTH];

  logic [IW-1:0] raddr;
  logic          rd_en, rd_pend, rd_armed;
  logic [63:0]   rd_due;
  logic [7:0]    rd_seq, rd_seq1;
  logic [31:0]   rd_rev, rd_rev1, rd_per;
  logic [7:0]    rd_trig;

  logic          wr;
  logic          n_en, n_pend, n_armed;
  logic [63:0]   n_due;
  logic [7:0]    n_seq, n_trig;
  logic [31:0]   n_rev, n_per;

  logic          emit;
  rsp_t          emit_data;
  logic [64:0]   sum;
  logic [63:0]   due_sat;
  logic          arm_ok;
  logic          hit, last, plan_ok;

  assign raddr    = (state == S_SCAN) ? scan_idx[IW-1:0] : cur.req.entry_index[IW-1:0];
  assign rd_en    = en_r[raddr];
  assign rd_pend  = pend_r[raddr];
  assign rd_armed = armed_r[raddr];
  assign rd_due   = due_r[raddr];
  assign rd_seq   = seq_r[raddr];
  assign rd_rev   = rev_r[raddr];
  assign rd_trig  = trig_r[raddr];
  assign rd_per   = per_r[raddr];
  assign rd_seq1  = rd_seq + 8'd1;
  assign rd_rev1  = (rd_rev == 32'hFFFF_FFFF) ? 32'd1 : rd_rev + 32'd1;

  assign sum     = {1'b0, cur.req.now_ms} + {33'd0, effp};
  assign due_sat = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
  assign arm_ok  = ((rd_trig & TRIG_INTEGRITY) != 8'd0) && (effp != 32'd0);

  assign hit  = scan_pass ? (rd_en && rd_armed && (cur.req.now_ms >= rd_due))
                          : (rd_en && rd_pend);
  assign last = ((scan_idx + 5'd1) >= live_count);

  always_comb begin
    plan_ok = rd_en && (cur.req.plan_revision == rd_rev) && (cur.req.plan_sequence == rd_seq1);
    case (cur.req.plan_reason)
      R_GI:        plan_ok = plan_ok && rd_pend;
      R_INTEGRITY: plan_ok = plan_ok && rd_armed;
      default:     plan_ok = 1'b0;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    wr        = 1'b0;
    n_en      = rd_en;
    n_pend    = rd_pend;
    n_armed   = rd_armed;
    n_due     = rd_due;
    n_seq     = rd_seq;
    n_rev     = rd_rev;
    n_trig    = rd_trig;
    n_per     = rd_per;
    case (state)
      S_IDLE: begin
        if (q_valid && !rsp_valid) begin
          q_pop = 1'b1;
          if (q_data.bad_func) begin
            emit = 1'b1;
            emit_data.status = ST_INVALID;
          end else if (q_data.bad_index) begin
            emit = 1'b1;
            emit_data.status = ST_RANGE;
          end
        end
      end
      S_EXEC: begin
        emit = 1'b1;
        case (cur.req.func)
          F_SET_ENABLE: begin
            if (rd_en != cur.req.enable_flag) begin
              wr     = 1'b1;
              n_en   = cur.req.enable_flag;
              n_pend = 1'b0;
              n_rev  = rd_rev1;
              if (cur.req.enable_flag) begin
                n_seq   = 8'd0;
                n_armed = arm_ok;
                n_due   = arm_ok ? due_sat : 64'd0;
              end else begin
                n_armed = 1'b0;
                n_due   = 64'd0;
              end
            end
          end
          F_SET_TRIGGER: begin
            if (rd_en) begin
              emit_data.status = ST_DENIED;
            end else if ((cur.req.setting_value & ~TRIG_ALLOWED) != 32'd0) begin
              emit_data.status = ST_INVALID;
            end else if (rd_trig != cur.req.setting_value[7:0]) begin
              wr     = 1'b1;
              n_trig = cur.req.setting_value[7:0];
              n_rev  = rd_rev1;
            end
          end
          F_SET_PERIOD: begin
            if (rd_en) begin
              emit_data.status = ST_DENIED;
            end else if (rd_per != cur.req.setting_value) begin
              wr    = 1'b1;
              n_per = cur.req.setting_value;
              n_rev = rd_rev1;
            end
          end
          F_REQUEST_GI: begin
            if (!rd_en) begin
              emit_data.status = ST_UNAVAILABLE;
            end else if (!rd_pend) begin
              wr     = 1'b1;
              n_pend = 1'b1;
              n_rev  = rd_rev1;
            end
          end
          F_COMMIT: begin
            if (!plan_ok) begin
              emit_data.status = ST_STALE;
            end else begin
              wr    = 1'b1;
              n_seq = cur.req.plan_sequence;
              n_rev = rd_rev1;
              if (cur.req.plan_reason == R_GI) begin
                n_pend = 1'b0;
              end else begin
                n_armed = arm_ok;
                n_due   = arm_ok ? due_sat : 64'd0;
              end
            end
          end
          default: emit_data.status = ST_INVALID;
        endcase
      end
      S_SCAN: begin
        if (live_count == 5'd0) begin
          emit = 1'b1;
        end else if (hit) begin
          emit = 1'b1;
          emit_data.due_found    = 1'b1;
          emit_data.due_index    = scan_idx[3:0];
          emit_data.due_revision = rd_rev;
          emit_data.due_sequence = rd_seq1;
          emit_data.due_reason   = scan_pass ? R_INTEGRITY : R_GI;
        end else if (last && scan_pass) begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      scan_idx  <= 5'd0;
      scan_pass <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        en_r[i]    <= 1'b0;
        pend_r[i]  <= 1'b0;
        armed_r[i] <= 1'b0;
        due_r[i]   <= 64'd0;
        seq_r[i]   <= 8'd0;
        rev_r[i]   <= 32'd1;
        trig_r[i]  <= 8'd0;
        per_r[i]   <= 32'd0;
      end
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (wr) begin
        en_r[raddr]    <= n_en;
        pend_r[raddr]  <= n_pend;
        armed_r[raddr] <= n_armed;
        due_r[raddr]   <= n_due;
        seq_r[raddr]   <= n_seq;
        rev_r[raddr]   <= n_rev;
        trig_r[raddr]  <= n_trig;
        per_r[raddr]   <= n_per;
      end
      case (state)
        S_IDLE: begin
          if (q_pop && !emit) begin
            scan_idx  <= 5'd0;
            scan_pass <= 1'b0;
            state     <= (q_data.req.func == F_POLL_DUE) ? S_SCAN : S_PREP;
          end
        end
        S_PREP: state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        S_SCAN: begin
          if (emit) begin
            state <= S_IDLE;
          end else if (last) begin
            scan_idx  <= 5'd0;
            scan_pass <= 1'b1;
          end else begin
            scan_idx <= scan_idx + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (emit) rsp <= emit_data;
    if (state == S_PREP) begin
      effp <= (rd_per == 32'd0) ? 32'd0 : ((rd_per < min_period) ? min_period : rd_per);
    end
  end

  `RBS_ASSERT_IMP(a_emit_slot_free, clk, rst, emit, !rsp_valid)
  `RBS_ASSERT_IMP(a_found_reason, clk, rst, emit && emit_data.due_found,
                  emit_data.due_reason == R_GI || emit_data.due_reason == R_INTEGRITY)
  `RBS_ASSERT_IMP(a_rev_nonzero, clk, rst, state == S_EXEC, rd_rev != 32'd0)
  `RBS_ASSERT_IMP(a_scan_in_range, clk, rst, state == S_SCAN && live_count != 5'd0,
                  scan_idx < live_count)
  `RBS_ASSERT_NXT(a_exec_after_prep, clk, rst, state == S_PREP, state == S_EXEC)

endmodule

[rtl/report_block_scheduler.sv]
// Report block scheduler: a table of up to sixteen report control entries.
// Each request performs one operation and returns exactly one response. The
// back end takes a request only while its response register is empty. A
// request refused by the front classification (unknown operation, index out
// of range) gets its response straight from the back end's idle state. Set,
// request and commit operations pass through take, period read and execute.
// A poll is taken and then walks the table one entry per cycle,
// interrogation pass first and then integrity pass, and ends at the first
// due entry, after the integrity pass, or with an empty response when no
// entries are in use. The entry table has a single read port. A two-deep
// request queue and a response register keep both sides decoupled.
// Configuration writes are always ready and take effect at once.
// Depends on rbs_pkg, rbs_front and rbs_back.
module report_block_scheduler import rbs_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int unsigned DEPTH = (MAX_ENTRIES < ADDRESSABLE) ? MAX_ENTRIES : ADDRESSABLE;
  localparam logic [4:0]  DEPTH_W = 5'(DEPTH);

  logic [4:0]  entry_count;
  logic [31:0] min_period;
  logic [4:0]  live_count;
  logic        q_valid;
  logic        q_pop;
  qent_t       q_data;

  assign cfg_ready  = 1'b1;
  assign live_count = (entry_count > DEPTH_W) ? DEPTH_W : entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 5'd16;
      min_period  <= 32'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: entry_count <= cfg_data[4:0];
        CFG_MIN_PERIOD:  min_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  rbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .live_count (live_count),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  rbs_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .live_count (live_count),
    .min_period (min_period),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule
